// ----- rtl/alt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// alt_pkg: allocation ledger tracker shared types and codes
// Request and result structs, command and status codes, sequencer states.
// ----------------------------------------------------------------------------
package alt_pkg;

	localparam int AddrW = 48;

	typedef enum logic [2:0] {
		CMD_ALLOC = 3'd0,
		CMD_FREE  = 3'd1,
		CMD_SNAP  = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_QUERY = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_DOUBLE  = 3'd1,
		ST_WILD    = 3'd2,
		ST_FULL    = 3'd3,
		ST_IGNORED = 3'd4
	} status_t;

	typedef struct packed {
		logic [2:0]       command;
		logic [AddrW-1:0] address;
		logic [31:0]      alloc_size;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] total_allocs;
		logic [31:0] total_frees;
		logic [31:0] double_free_count;
		logic [31:0] wild_free_count;
		logic [8:0]  live_count;
		logic [8:0]  leaks_since_snapshot;
		logic [39:0] leaked_bytes;
		logic [39:0] leaked_bytes_since_snapshot;
		logic signed [31:0] net_balance_since_snapshot;
		logic        overflow_seen;
		logic [31:0] prior_sequence;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SCAN_LAST,
		S_WRITE,
		S_REREAD,
		S_SUM,
		S_SUM_LAST,
		S_OUT
	} state_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/alt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// alt_ram: generic simple dual-port RAM (separate write and read addresses)
// One write and one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module alt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/allocation_ledger_tracker_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// allocation_ledger_tracker_top: allocation ledger with leak accounting
// Sequencer walks the ledger RAM for match search, then for leak totals.
// ----------------------------------------------------------------------------
// channel  | dir | handshake        | payload
// req      | in  | req_valid/ready  | alt_pkg::req_t
// rsp      | out | rsp_valid/ready  | alt_pkg::rsp_t
// cfg      | in  | cfg_we           | cfg_wdata (tracking_enable)
//
// An alloc or free with tracking on and a non-null address goes through
// decode, one pass over the ledger RAM read port to find a match or slot,
// a write, one read turnaround, one pass to sum live entries, and the result.
// Other requests skip the search, write and turnaround. Clear adds a sweep
// that sets the entries back to zero before the next request is taken.
// Reset starts with a clearing pass; no request is taken during it.
// Stalls on rsp hold the result; req_ready stays low.
// ----------------------------------------------------------------------------
module allocation_ledger_tracker_top #(
	parameter int LEDGER_DEPTH = 256
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire alt_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output alt_pkg::rsp_t      rsp,
	input  wire logic          cfg_we,
	input  wire logic          cfg_wdata
);
	localparam int IW = $clog2(LEDGER_DEPTH);
	localparam int EW = 1 + alt_pkg::AddrW + 32 + 32;

	typedef struct packed {
		logic                     live;
		logic [alt_pkg::AddrW-1:0] addr;
		logic [31:0]              bytes;
		logic [31:0]              seq;
	} entry_t;

	alt_pkg::state_t st_q, st_d;

	logic en_q;
	logic [2:0] cmd_q;
	logic [alt_pkg::AddrW-1:0] addr_q;
	logic [31:0] size_q;
	logic [IW-1:0] idx_q;
	logic clr_q;
	logic [31:0] seq_q, snap_seq_q, snap_al_q, snap_fr_q;
	logic [31:0] al_q, fr_q, df_q, wf_q, prior_q;
	logic ovf_q;
	logic [2:0] status_q;
	// search results
	logic hit_live_q, hit_dbl_q, hit_new_q, hit_any_q;
	logic [IW-1:0] live_i_q, new_i_q, any_i_q;
	logic [31:0] dbl_seq_q;
	entry_t live_e_q;
	// sums
	logic [9:0] cnt_q, cnt_new_q;
	logic [40:0] sum_q, sum_new_q;

	logic we;
	logic [IW-1:0] waddr;
	entry_t wdata, rd;
	logic [EW-1:0] rd_bits;
	assign rd = entry_t'(rd_bits);

	alt_ram #(.WIDTH(EW), .DEPTH(LEDGER_DEPTH)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(EW'(wdata)),
		.raddr(idx_q),
		.rdata(rd_bits)
	);

	logic last_idx;
	assign last_idx = (idx_q == IW'(LEDGER_DEPTH - 1));
	logic [IW-1:0] prev_idx;
	assign prev_idx = idx_q - IW'(1);
	logic addr_eq;
	assign addr_eq = (rd.addr == addr_q);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			alt_pkg::S_IDLE: begin
				if (clr_q) begin
					if (last_idx) st_d = alt_pkg::S_IDLE;
				end else if (req_valid) begin
					st_d = alt_pkg::S_DECODE;
				end
			end
			alt_pkg::S_DECODE: begin
				if ((cmd_q == alt_pkg::CMD_ALLOC || cmd_q == alt_pkg::CMD_FREE)
				    && en_q && addr_q != '0) begin
					st_d = alt_pkg::S_SCAN;
				end else begin
					st_d = alt_pkg::S_SUM;
				end
			end
			alt_pkg::S_SCAN:      if (last_idx) st_d = alt_pkg::S_SCAN_LAST;
			alt_pkg::S_SCAN_LAST: st_d = alt_pkg::S_WRITE;
			alt_pkg::S_WRITE:     st_d = alt_pkg::S_REREAD;
			alt_pkg::S_REREAD:    st_d = alt_pkg::S_SUM;
			alt_pkg::S_SUM:       if (last_idx) st_d = alt_pkg::S_SUM_LAST;
			alt_pkg::S_SUM_LAST:  st_d = alt_pkg::S_OUT;
			alt_pkg::S_OUT:       if (rsp_ready) st_d = alt_pkg::S_IDLE;
			default:              st_d = alt_pkg::S_IDLE;
		endcase
	end

	// outputs and RAM write port
	always_comb begin
		req_ready = (st_q == alt_pkg::S_IDLE) && !clr_q;
		rsp_valid = (st_q == alt_pkg::S_OUT);
		we = 1'b0;
		waddr = idx_q;
		wdata = '0;
		if (st_q == alt_pkg::S_IDLE && clr_q) begin
			we = 1'b1;
		end else if (st_q == alt_pkg::S_WRITE) begin
			if (cmd_q == alt_pkg::CMD_ALLOC && (hit_new_q || hit_any_q)) begin
				we = 1'b1;
				waddr = hit_new_q ? new_i_q : any_i_q;
				wdata.live = 1'b1;
				wdata.addr = addr_q;
				wdata.bytes = size_q;
				wdata.seq = seq_q;
			end else if (cmd_q == alt_pkg::CMD_FREE && hit_live_q) begin
				we = 1'b1;
				waddr = live_i_q;
				wdata = live_e_q;
				wdata.live = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= alt_pkg::S_IDLE;
			en_q <= 1'b0;
			clr_q <= 1'b1;
			idx_q <= '0;
			seq_q <= '0; snap_seq_q <= '0; snap_al_q <= '0; snap_fr_q <= '0;
			al_q <= '0; fr_q <= '0; df_q <= '0; wf_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) en_q <= cfg_wdata;
			unique case (st_q)
				alt_pkg::S_IDLE: begin
					if (clr_q) begin
						if (last_idx) begin
							clr_q <= 1'b0;
							idx_q <= '0;
						end else begin
							idx_q <= idx_q + IW'(1);
						end
					end else if (req_valid) begin
						cmd_q <= req.command;
						addr_q <= req.address;
						size_q <= req.alloc_size;
						idx_q <= '0;
					end
				end
				alt_pkg::S_DECODE: begin
					// apply counters and codes that need no search
					status_q <= alt_pkg::ST_OK;
					prior_q <= '0;
					hit_live_q <= 1'b0; hit_dbl_q <= 1'b0;
					hit_new_q <= 1'b0; hit_any_q <= 1'b0;
					idx_q <= IW'(1);
					if (cmd_q == alt_pkg::CMD_ALLOC || cmd_q == alt_pkg::CMD_FREE) begin
						if (!en_q || addr_q == '0) begin
							status_q <= alt_pkg::ST_IGNORED;
						end else if (cmd_q == alt_pkg::CMD_ALLOC) begin
							al_q <= alt_pkg::sat_inc(al_q);
							seq_q <= alt_pkg::sat_inc(seq_q);
						end else begin
							fr_q <= alt_pkg::sat_inc(fr_q);
						end
					end else if (cmd_q == alt_pkg::CMD_SNAP) begin
						snap_seq_q <= seq_q; snap_al_q <= al_q; snap_fr_q <= fr_q;
					end else if (cmd_q == alt_pkg::CMD_CLEAR) begin
						seq_q <= '0; snap_seq_q <= '0; snap_al_q <= '0; snap_fr_q <= '0;
						al_q <= '0; fr_q <= '0; df_q <= '0; wf_q <= '0;
						ovf_q <= 1'b0;
						clr_q <= 1'b1;
					end else if (cmd_q != alt_pkg::CMD_QUERY) begin
						status_q <= alt_pkg::ST_IGNORED;
					end
					cnt_q <= '0; cnt_new_q <= '0; sum_q <= '0; sum_new_q <= '0;
				end
				alt_pkg::S_SCAN, alt_pkg::S_SCAN_LAST: begin
					// rd holds entry prev_idx; keep the lowest hit of each kind
					if (st_q == alt_pkg::S_SCAN) idx_q <= idx_q + IW'(1);
					else idx_q <= '0;
					if (!hit_live_q && rd.live && addr_eq) begin
						hit_live_q <= 1'b1; live_i_q <= prev_idx; live_e_q <= rd;
					end
					if (!hit_dbl_q && !rd.live && rd.seq != '0 && addr_eq) begin
						hit_dbl_q <= 1'b1; dbl_seq_q <= rd.seq;
					end
					if (!hit_new_q && !rd.live && rd.seq == '0) begin
						hit_new_q <= 1'b1; new_i_q <= prev_idx;
					end
					if (!hit_any_q && !rd.live) begin
						hit_any_q <= 1'b1; any_i_q <= prev_idx;
					end
				end
				alt_pkg::S_WRITE: begin
					// hold the read address at entry 0 until the write has landed
					idx_q <= '0;
					if (cmd_q == alt_pkg::CMD_ALLOC) begin
						if (!(hit_new_q || hit_any_q)) begin
							ovf_q <= 1'b1;
							status_q <= alt_pkg::ST_FULL;
						end
					end else if (!hit_live_q) begin
						if (hit_dbl_q) begin
							df_q <= alt_pkg::sat_inc(df_q);
							prior_q <= dbl_seq_q;
							status_q <= alt_pkg::ST_DOUBLE;
						end else begin
							wf_q <= alt_pkg::sat_inc(wf_q);
							status_q <= alt_pkg::ST_WILD;
						end
					end
				end
				alt_pkg::S_REREAD: begin
					// entry 0 is read after the write, advance to entry 1
					idx_q <= IW'(1);
				end
				alt_pkg::S_SUM, alt_pkg::S_SUM_LAST: begin
					// first cycle of S_SUM reads entry 0, whose read was issued in the previous cycle
					if (st_q == alt_pkg::S_SUM) idx_q <= idx_q + IW'(1);
					else idx_q <= '0;
					if (rd.live && !clr_q) begin
						cnt_q <= cnt_q + 10'd1;
						sum_q <= sum_q + 41'(rd.bytes);
						if (rd.seq > snap_seq_q) begin
							cnt_new_q <= cnt_new_q + 10'd1;
							sum_new_q <= sum_new_q + 41'(rd.bytes);
						end
					end
				end
				alt_pkg::S_OUT: begin
					if (rsp_ready) idx_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// result assembly
	always_comb begin
		rsp.status = status_q;
		rsp.total_allocs = al_q;
		rsp.total_frees = fr_q;
		rsp.double_free_count = df_q;
		rsp.wild_free_count = wf_q;
		rsp.live_count = cnt_q[9] ? 9'd511 : cnt_q[8:0];
		rsp.leaks_since_snapshot = cnt_new_q[9] ? 9'd511 : cnt_new_q[8:0];
		rsp.leaked_bytes = sum_q[40] ? {40{1'b1}} : sum_q[39:0];
		rsp.leaked_bytes_since_snapshot = sum_new_q[40] ? {40{1'b1}} : sum_new_q[39:0];
		rsp.net_balance_since_snapshot = (al_q - snap_al_q) - (fr_q - snap_fr_q);
		rsp.overflow_seen = ovf_q;
		rsp.prior_sequence = prior_q;
	end
endmodule
`default_nettype wire
